// ===== sv/dadw_pkg.sv =====
// Package for the date adder and weekday block.
// Holds payload structs, microcode types, status codes and calendar tables.
// No dependencies; every other file imports it.
package dadw_pkg;

  localparam int unsigned MAX_ADD_DAYS = 65535;
  localparam int unsigned YEAR_LIMIT   = 9999;
  localparam int unsigned WD_BIAS      = 7000;

  // x / 100 == (x * RECIP_100) >> RECIP_100_SH for x below 2**14.
  localparam logic [12:0] RECIP_100    = 13'd5243;
  localparam int unsigned RECIP_100_SH = 19;
  // x / 7 == (x * RECIP_7) >> RECIP_7_SH for x below 2**15.
  localparam logic [14:0] RECIP_7      = 15'd18725;
  localparam int unsigned RECIP_7_SH   = 17;

  typedef logic [3:0] upc_t;

  localparam upc_t UPC_IDLE   = 4'd0;
  localparam upc_t UPC_ROLL   = 4'd8;
  localparam upc_t UPC_FINISH = 4'd14;
  localparam upc_t UPC_OUT    = 4'd15;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_LEAP_MUL,
    OP_LEAP,
    OP_CHECK,
    OP_WD_MUL100,
    OP_WD_SUM,
    OP_WD_MUL7,
    OP_WD_MOD,
    OP_ROLL,
    OP_FINISH,
    OP_OUT
  } uop_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_BAD_DATE,
    C_ROLL_DONE,
    C_SAME_YEAR,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    uop_e  op;
    cond_e cond;
    upc_t  target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic bad_date;
    logic roll_done;
    logic same_year;
  } dp_flags_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_MONTH = 3'd1,
    ST_BAD_DAY   = 3'd2,
    ST_YEAR_ZERO = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  typedef struct packed {
    logic [4:0]  day_in;
    logic [3:0]  month_in;
    logic [13:0] year_in;
    logic [15:0] add_days;
  } date_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  weekday_out;
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [13:0] year_out;
  } date_out_t;

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // (31 * mm) / 12 for the March-based month index mm.
  function automatic logic [4:0] month_offset(logic [3:0] mm);
    logic [4:0] off;
    unique case (mm)
      4'd1:    off = 5'd2;
      4'd2:    off = 5'd5;
      4'd3:    off = 5'd7;
      4'd4:    off = 5'd10;
      4'd5:    off = 5'd12;
      4'd6:    off = 5'd15;
      4'd7:    off = 5'd18;
      4'd8:    off = 5'd20;
      4'd9:    off = 5'd23;
      4'd10:   off = 5'd25;
      4'd11:   off = 5'd28;
      4'd12:   off = 5'd31;
      default: off = 5'd0;
    endcase
    return off;
  endfunction

endpackage

// ===== sv/date_add_days_weekday.sv =====
// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_ready_o    in_data_i  (dadw_pkg::date_in_t)
// output    out        out_valid_o / out_ready_i  out_data_o (dadw_pkg::date_out_t)
//
// One transaction at a time. An invalid date goes from the check step straight
// to the output step; a valid one also computes the weekday and then runs the
// microcode loop that rolls the date one month per pass, recomputing the leap
// flag at each new year. Reset clears the sequencer and the output valid flag;
// no clearing pass. A stalled output holds the sequencer on its last step, and
// input is taken again once the result moves.
module date_add_days_weekday (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dadw_pkg::date_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dadw_pkg::date_out_t out_data_o
);
  import dadw_pkg::*;

  uword_t    ctrl;
  dp_flags_t flags;

  dadw_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  dadw_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .flags_o     (flags),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sv/dadw_useq.sv =====
// Microcode sequencer: program counter, control ROM and conditional jumps.
// Depends on dadw_pkg for the control word and flag types.
module dadw_useq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dadw_pkg::dp_flags_t flags_i,
  output dadw_pkg::uword_t    ctrl_o
);
  import dadw_pkg::*;

  upc_t   pc_q, pc_d;
  uword_t uw;
  logic   take;

  always_comb begin
    unique case (pc_q)
      4'd0:    uw = '{op: OP_LOAD,      cond: C_NO_INPUT,  target: UPC_IDLE};
      4'd1:    uw = '{op: OP_LEAP_MUL,  cond: C_NEVER,     target: UPC_IDLE};
      4'd2:    uw = '{op: OP_LEAP,      cond: C_NEVER,     target: UPC_IDLE};
      4'd3:    uw = '{op: OP_CHECK,     cond: C_BAD_DATE,  target: UPC_OUT};
      4'd4:    uw = '{op: OP_WD_MUL100, cond: C_NEVER,     target: UPC_IDLE};
      4'd5:    uw = '{op: OP_WD_SUM,    cond: C_NEVER,     target: UPC_IDLE};
      4'd6:    uw = '{op: OP_WD_MUL7,   cond: C_NEVER,     target: UPC_IDLE};
      4'd7:    uw = '{op: OP_WD_MOD,    cond: C_NEVER,     target: UPC_IDLE};
      4'd8:    uw = '{op: OP_ROLL,      cond: C_ROLL_DONE, target: UPC_FINISH};
      4'd9:    uw = '{op: OP_NONE,      cond: C_SAME_YEAR, target: UPC_ROLL};
      // A new year starts: recompute the leap flag, then resume the roll.
      4'd10:   uw = '{op: OP_LEAP_MUL,  cond: C_NEVER,     target: UPC_IDLE};
      4'd11:   uw = '{op: OP_LEAP,      cond: C_ALWAYS,    target: UPC_ROLL};
      4'd14:   uw = '{op: OP_FINISH,    cond: C_NEVER,     target: UPC_IDLE};
      // The last step loads the result and falls through to step zero once the output is not stalled.
      4'd15:   uw = '{op: OP_OUT,       cond: C_OUT_BUSY,  target: UPC_OUT};
      default: uw = '{op: OP_NONE,      cond: C_ALWAYS,    target: UPC_IDLE};
    endcase
  end

  always_comb begin
    unique case (uw.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_INPUT:  take = ~flags_i.in_valid;
      C_BAD_DATE:  take = flags_i.bad_date;
      C_ROLL_DONE: take = flags_i.roll_done;
      C_SAME_YEAR: take = flags_i.same_year;
      C_OUT_BUSY:  take = flags_i.out_busy;
      default:     take = 1'b1;
    endcase
    pc_d = take ? uw.target : pc_q + 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= UPC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = uw;

endmodule

// ===== sv/dadw_datapath.sv =====
// Datapath: date registers, a product register shared by the constant multiplies,
// checks, roll-over logic and the output register. Driven by the sequencer's control word.
// Depends on dadw_pkg.
module dadw_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dadw_pkg::uword_t    ctrl_i,
  output dadw_pkg::dp_flags_t flags_o,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dadw_pkg::date_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dadw_pkg::date_out_t out_data_o
);
  import dadw_pkg::*;

  logic [4:0]  day_q;
  logic [3:0]  month_q;
  logic [13:0] year_q;
  logic [15:0] left_q;
  logic        leap_q;
  logic        wrap_q;
  logic [29:0] prod_q;
  logic [14:0] sum_q;
  logic [2:0]  wd_q;
  status_e     status_q;
  logic        out_valid_q, out_valid_d;
  date_out_t   out_q;

  logic        in_fire;
  logic [15:0] add_sat;
  logic [7:0]  q100;
  logic [13:0] rem100;
  logic        leap_calc;
  status_e     check_status;
  logic        jan_feb;
  logic [13:0] yy;
  logic [3:0]  mm;
  logic [14:0] sum_calc;
  logic [12:0] q7;
  logic [14:0] wd_diff;
  logic [4:0]  mlen;
  logic [16:0] reach;
  logic        fits;
  logic [15:0] used;
  logic        year_over;
  logic        out_busy;
  logic        out_load;
  logic        date_ok;
  logic        wd_ok;

  assign in_ready_o = (ctrl_i.op == OP_LOAD);
  assign in_fire    = in_valid_i & in_ready_o;
  assign add_sat    = (32'(in_data_i.add_days) > MAX_ADD_DAYS) ? 16'(MAX_ADD_DAYS)
                                                               : in_data_i.add_days;

  // Leap rule from the quotient and remainder by 100; y / 400 is q100 / 4.
  assign q100      = prod_q[RECIP_100_SH +: 8];
  assign rem100    = year_q - 14'(16'(q100) * 16'd100);
  assign leap_calc = ((year_q[1:0] == 2'd0) && (rem100 != 14'd0)) ||
                     ((rem100 == 14'd0) && (q100[1:0] == 2'd0));

  assign mlen = month_len(month_q, leap_q);

  always_comb begin
    if ((month_q < 4'd1) || (month_q > 4'd12)) begin
      check_status = ST_BAD_MONTH;
    end else if ((day_q < 5'd1) || (day_q > mlen)) begin
      check_status = ST_BAD_DAY;
    end else if (year_q == 14'd0) begin
      check_status = ST_YEAR_ZERO;
    end else begin
      check_status = ST_OK;
    end
  end

  // Weekday with January and February counted as months of the prior year.
  assign jan_feb  = (month_q <= 4'd2);
  assign yy       = year_q - {13'd0, jan_feb};
  assign mm       = jan_feb ? (month_q + 4'd10) : (month_q - 4'd2);
  assign sum_calc = 15'(WD_BIAS) + 15'(day_q) + 15'(yy) + 15'(yy >> 2) - 15'(q100)
                  + 15'(q100 >> 2) + 15'(month_offset(mm));
  assign q7       = prod_q[RECIP_7_SH +: 13];
  assign wd_diff  = sum_q - 15'(16'(q7) * 16'd7);

  assign reach     = 17'(day_q) + 17'(left_q);
  assign fits      = reach <= 17'(mlen);
  assign used      = 16'(mlen) - 16'(day_q) + 16'd1;
  assign year_over = year_q > 14'(YEAR_LIMIT);

  assign out_busy = out_valid_q & ~out_ready_i;
  assign out_load = (ctrl_i.op == OP_OUT) & ~out_busy;

  assign flags_o = '{in_valid:  in_valid_i,
                     out_busy:  out_busy,
                     bad_date:  (check_status != ST_OK),
                     roll_done: year_over | fits,
                     same_year: ~wrap_q};

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      OP_LOAD: begin
        if (in_fire) begin
          day_q   <= in_data_i.day_in;
          month_q <= in_data_i.month_in;
          year_q  <= in_data_i.year_in;
          left_q  <= add_sat;
        end
      end
      OP_LEAP_MUL:  prod_q   <= 30'(27'(year_q) * 27'(RECIP_100));
      OP_LEAP:      leap_q   <= leap_calc;
      OP_CHECK:     status_q <= check_status;
      OP_WD_MUL100: prod_q   <= 30'(27'(yy) * 27'(RECIP_100));
      OP_WD_SUM:    sum_q    <= sum_calc;
      OP_WD_MUL7:   prod_q   <= 30'(sum_q) * 30'(RECIP_7);
      OP_WD_MOD:    wd_q     <= wd_diff[2:0];
      OP_ROLL: begin
        if (!year_over) begin
          if (fits) begin
            day_q <= 5'(reach);
          end else begin
            left_q <= left_q - used;
            day_q  <= 5'd1;
            if (month_q == 4'd12) begin
              month_q <= 4'd1;
              year_q  <= year_q + 14'd1;
              wrap_q  <= 1'b1;
            end else begin
              month_q <= month_q + 4'd1;
              wrap_q  <= 1'b0;
            end
          end
        end
      end
      OP_FINISH: begin
        if (year_over) begin
          status_q <= ST_OVERFLOW;
        end
      end
      default: ;
    endcase
  end

  assign date_ok = (status_q == ST_OK);
  assign wd_ok   = (status_q == ST_OK) || (status_q == ST_OVERFLOW);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.status      <= status_q;
      out_q.weekday_out <= wd_ok ? wd_q : 3'd0;
      out_q.day_out     <= date_ok ? day_q : 5'd0;
      out_q.month_out   <= date_ok ? month_q : 4'd0;
      out_q.year_out    <= date_ok ? year_q : 14'd0;
    end
  end

  assign out_valid_d = out_load | out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/dadw_checker.sv =====
// Port-level checker for the date adder, attached to the top level by bind.
// Depends on dadw_pkg for payload types and status codes.
module dadw_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input dadw_pkg::date_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input dadw_pkg::date_out_t out_data_o
);
  import dadw_pkg::*;

  // A result waiting for the sink holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  // A rejected date shows no weekday and no result date.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_BAD_MONTH ||
                    out_data_o.status == ST_BAD_DAY ||
                    out_data_o.status == ST_YEAR_ZERO)
    |-> out_data_o.weekday_out == 3'd0 && out_data_o.day_out == 5'd0 &&
        out_data_o.month_out == 4'd0 && out_data_o.year_out == 14'd0)
    else $error("rejected date carries nonzero fields");

  // An overflowed result keeps the weekday but clears the date.
  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_OVERFLOW
    |-> out_data_o.day_out == 5'd0 && out_data_o.month_out == 4'd0 &&
        out_data_o.year_out == 14'd0 && out_data_o.weekday_out <= 3'd6)
    else $error("overflow result carries a date");

  // A good result is a real calendar date within range.
  a_ok_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_OK
    |-> out_data_o.day_out != 5'd0 && out_data_o.month_out != 4'd0 &&
        out_data_o.month_out <= 4'd12 && out_data_o.year_out != 14'd0 &&
        out_data_o.year_out <= 14'(YEAR_LIMIT) && out_data_o.weekday_out <= 3'd6)
    else $error("good result outside calendar range");

endmodule

bind date_add_days_weekday dadw_checker u_dadw_checker (.*);
